/* src/tcw_pkg.sv */
package tcw_pkg;

	localparam int LIN_W = 16;
	localparam int POS_W = 15;
	localparam int CH_W  = 8;
	localparam int AT_W  = 8;

	localparam logic [1:0] CMD_PRINT = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	localparam logic [0:0] CFG_DEFAULT_ATTR = 1'b0;
	localparam logic [0:0] CFG_ERROR_ATTR   = 1'b1;

	localparam logic [CH_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CH_W-1:0] CH_ERROR   = 8'd69;
	localparam logic [CH_W-1:0] CH_SPACE   = 8'd32;

	localparam logic [AT_W-1:0] DEFAULT_ATTR_RST = 8'd15;
	localparam logic [AT_W-1:0] ERROR_ATTR_RST   = 8'd244;

	// sweep kinds
	localparam logic [1:0] SW_ZERO   = 2'd0;
	localparam logic [1:0] SW_BLANK  = 2'd1;
	localparam logic [1:0] SW_SCROLL = 2'd2;

	typedef struct packed {
		logic [AT_W-1:0]  read_attribute;
		logic [CH_W-1:0]  read_character;
		logic [POS_W-1:0] next_position;
		logic             out_of_range;
	} res_t;

endpackage

/* src/tcw_cell_ram.sv */
module tcw_cell_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* src/text_console_writer.sv */
// Results of a print or newline without a scroll, out-of-range and no-op results pass the result
// and output registers; an in-range read passes ST_READ first. Throughput: one item per cycle for those
// while m_tready does not stall the output. A scroll or a clear walks the cell RAM, one cell a cycle.
// Reset: arst_n resets cursor, control and attribute registers at once; then a clearing pass
// zeroes the cell RAM while s_tready stays low.
module text_console_writer #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // character[7:0], attribute[15:8], column[23:16], line[31:24]
	input  logic [2:0]  s_tuser,   // command[1:0], use_cursor[2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // next_position[14:0], read_character[22:15],
	                               // read_attribute[30:23], zero[31]
	output logic [0:0]  m_tuser,   // out_of_range[0]
	input  logic        cfg_wr_en,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int CELLS = ROWS * COLS;
	localparam int AW    = $clog2(CELLS);
	localparam int LW    = tcw_pkg::LIN_W;
	localparam int PW    = tcw_pkg::POS_W;

	localparam logic [LW-1:0] COLS_L   = LW'(COLS);
	localparam logic [LW-1:0] CELLS_L  = LW'(CELLS);
	localparam logic [8:0]    COLS_W   = 9'(COLS);
	localparam logic [8:0]    ROWS_W   = 9'(ROWS);
	localparam logic [AW-1:0] LAST_A   = AW'(CELLS - 1);
	localparam logic [AW-1:0] MOVE_END = AW'(CELLS - COLS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0]    state_q;
	logic [1:0]    kind_q;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] cur_lin_q;
	logic [7:0]    cur_col_q;
	logic [7:0]    dflt_q;
	logic [7:0]    err_q;

	logic                res_vld_q;
	tcw_pkg::res_t       res_q;
	logic                out_vld_q;
	tcw_pkg::res_t       out_q;
	tcw_pkg::res_t       res_d;

	logic          wr_vld_s1;
	logic [AW-1:0] wr_addr_s1;
	logic          wr_rd_s1;
	logic [15:0]   wr_fill_s1;

	logic [1:0]  cmd;
	logic        use_cur;
	logic [7:0]  ch;
	logic [7:0]  attr;
	logic [7:0]  col;
	logic [7:0]  row;

	logic          accept;
	logic          move;
	logic          in_screen;
	logic          print_oor;
	logic          is_nl;
	logic          scroll;
	logic          imm_res;
	logic          set_res;
	logic [LW-1:0] lin;
	logic [LW-1:0] tgt_lin;
	logic [7:0]    tgt_col;
	logic [LW-1:0] adv_lin;
	logic [LW-1:0] nxt_lin;
	logic [8:0]    col_inc;
	logic [7:0]    nxt_col;
	logic [7:0]    attr_eff;
	logic [LW-1:0] cur_lin16;
	logic [AW:0]   swp_sum;

	logic          acc_we;
	logic [AW-1:0] acc_waddr;
	logic [15:0]   acc_wdata;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;

	assign cmd     = s_tuser[1:0];
	assign use_cur = s_tuser[2];
	assign ch      = s_tdata[7:0];
	assign attr    = s_tdata[15:8];
	assign col     = s_tdata[23:16];
	assign row     = s_tdata[31:24];

	assign move     = res_vld_q && (!out_vld_q || m_tready);
	assign s_tready = (state_q == ST_IDLE) && (!res_vld_q || move);
	assign accept   = s_tvalid && s_tready;

	assign in_screen = ({1'b0, row} < ROWS_W) && ({1'b0, col} < COLS_W);
	assign lin       = LW'(row) * COLS_L + LW'(col);
	assign cur_lin16 = LW'(cur_lin_q);
	assign tgt_lin   = use_cur ? cur_lin16 : lin;
	assign tgt_col   = use_cur ? cur_col_q : col;
	assign is_nl     = (ch == tcw_pkg::CH_NEWLINE);
	assign print_oor = !use_cur && !in_screen;
	assign adv_lin   = is_nl ? (tgt_lin - LW'(tgt_col) + COLS_L) : (tgt_lin + LW'(1));
	assign scroll    = (adv_lin >= CELLS_L);
	assign nxt_lin   = scroll ? (adv_lin - COLS_L) : adv_lin;
	assign col_inc   = {1'b0, tgt_col} + 9'd1;
	assign nxt_col   = (is_nl || col_inc == COLS_W) ? 8'd0 : col_inc[7:0];
	assign attr_eff  = (attr == 8'd0) ? dflt_q : attr;
	assign swp_sum   = (AW+1)'(cnt_q) + (AW+1)'(COLS);

	always_comb begin
		acc_we    = 1'b0;
		acc_waddr = tgt_lin[AW-1:0];
		acc_wdata = {attr_eff, ch};
		res_d     = '0;
		res_d.next_position = cur_lin16[PW-1:0];
		imm_res   = 1'b0;
		case (cmd)
			tcw_pkg::CMD_PRINT: begin
				if (print_oor) begin
					acc_we    = 1'b1;
					acc_waddr = LAST_A;
					acc_wdata = {err_q, tcw_pkg::CH_ERROR};
					res_d.out_of_range  = 1'b1;
					res_d.next_position = lin[PW-1:0];
					imm_res   = 1'b1;
				end else begin
					acc_we  = !is_nl;
					res_d.next_position = nxt_lin[PW-1:0];
					imm_res = !scroll;
				end
			end
			tcw_pkg::CMD_READ: begin
				res_d.out_of_range = !in_screen;
				imm_res = !in_screen;
			end
			tcw_pkg::CMD_CLEAR: begin
				res_d.next_position = '0;
			end
			tcw_pkg::CMD_NOP: begin
				imm_res = 1'b1;
			end
			default: begin
				imm_res = 1'b1;
			end
		endcase
	end

	assign set_res = (accept && imm_res) || (state_q == ST_READ) ||
	                 (state_q == ST_DRAIN && kind_q != tcw_pkg::SW_ZERO);

	assign ram_we    = wr_vld_s1 || (accept && acc_we);
	assign ram_waddr = wr_vld_s1 ? wr_addr_s1 : acc_waddr;
	assign ram_wdata = wr_vld_s1 ? (wr_rd_s1 ? ram_rdata : wr_fill_s1) : acc_wdata;
	assign ram_raddr = (state_q == ST_SWEEP) ? swp_sum[AW-1:0] : lin[AW-1:0];

	tcw_cell_ram #(
		.DEPTH (CELLS),
		.AW    (AW),
		.DW    (16)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SWEEP;
			kind_q    <= tcw_pkg::SW_ZERO;
			cnt_q     <= '0;
			cur_lin_q <= '0;
			cur_col_q <= '0;
			wr_vld_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd)
							tcw_pkg::CMD_PRINT: begin
								if (!print_oor) begin
									cur_lin_q <= nxt_lin[AW-1:0];
									cur_col_q <= nxt_col;
									if (scroll) begin
										state_q <= ST_SWEEP;
										kind_q  <= tcw_pkg::SW_SCROLL;
										cnt_q   <= '0;
									end
								end
							end
							tcw_pkg::CMD_READ: begin
								if (in_screen) begin
									state_q <= ST_READ;
								end
							end
							tcw_pkg::CMD_CLEAR: begin
								cur_lin_q <= '0;
								cur_col_q <= '0;
								state_q   <= ST_SWEEP;
								kind_q    <= tcw_pkg::SW_BLANK;
								cnt_q     <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					wr_vld_s1 <= 1'b1;
					if (cnt_q == LAST_A) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					wr_vld_s1 <= 1'b0;
					state_q   <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SWEEP) begin
			wr_addr_s1 <= cnt_q;
			wr_rd_s1   <= (kind_q == tcw_pkg::SW_SCROLL) && (cnt_q < MOVE_END);
			wr_fill_s1 <= (kind_q == tcw_pkg::SW_BLANK) ? {dflt_q, tcw_pkg::CH_SPACE} : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_q <= tcw_pkg::DEFAULT_ATTR_RST;
			err_q  <= tcw_pkg::ERROR_ATTR_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tcw_pkg::CFG_DEFAULT_ATTR: dflt_q <= cfg_data;
				tcw_pkg::CFG_ERROR_ATTR:   err_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (set_res) begin
				res_vld_q <= 1'b1;
			end else if (move) begin
				res_vld_q <= 1'b0;
			end
			if (!out_vld_q || m_tready) begin
				out_vld_q <= res_vld_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end else if (state_q == ST_READ) begin
			res_q.read_character <= ram_rdata[7:0];
			res_q.read_attribute <= ram_rdata[15:8];
		end
		if (move) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_q.read_attribute, out_q.read_character, out_q.next_position};
	assign m_tuser  = out_q.out_of_range;

	// sweep write-back must never meet a transaction's write
	a_no_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		wr_vld_s1 |-> !accept)
		else $error("sweep write overlaps accepted transaction");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_lin16 < CELLS_L)
		else $error("cursor outside screen");

	a_read_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> $past(accept && cmd == tcw_pkg::CMD_READ && in_screen))
		else $error("read state without read transaction");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && !move) |=> res_vld_q)
		else $error("pending result lost");

endmodule
